/* hw/rtl/bfb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter bank package
// Shared widths, sizes and the sixteen fixed bit-index functions.
// ----------------------------------------------------------------------------
package bfb_pkg;

  localparam int unsigned HashW          = 64;
  localparam int unsigned WordW          = 32;
  localparam int unsigned FilterBits     = 16384;
  localparam int unsigned IdxW           = $clog2(FilterBits);
  localparam int unsigned OffW           = $clog2(WordW);
  localparam int unsigned WordsPerFilter = FilterBits / WordW;
  localparam int unsigned WordAddrW      = $clog2(WordsPerFilter);
  localparam int unsigned SelW           = 4;
  localparam int unsigned HashFnCount    = 16;

  // Rotate left; a shift by the full width yields zero, so a zero amount
  // leaves the value unchanged.
  function automatic logic [HashW-1:0] bfb_rotl(input logic [HashW-1:0] v,
                                                input logic [5:0] amt);
    logic [6:0] rev;
    rev = 7'd64 - {1'b0, amt};
    return (v << amt) | (v >> rev);
  endfunction

  // Bit index of hash function fn. Functions 0 to 5 take the top bits of a
  // rotation, 6 to 11 the top bits of the XOR of two rotations, 12 and 13
  // fold bit pairs of one word, 14 folds bit triples and 15 bit quads.
  function automatic logic [IdxW-1:0] bfb_index(input logic [3:0] fn,
                                                input logic [HashW-1:0] h);
    logic [HashW-1:0] x;
    logic [HashW-1:0] y;
    logic [5:0]       k;
    logic [IdxW-1:0]  r;
    x = '0;
    y = '0;
    k = '0;
    r = '0;
    if (fn < 4'd6) begin
      x = bfb_rotl(h, 6'(14 * fn));
      r = x[HashW-1 -: IdxW];
    end else if (fn < 4'd12) begin
      k = 6'(fn - 4'd6);
      x = bfb_rotl(h, 6'(14 * k + 10));
      y = bfb_rotl(h, 6'(14 * k + 24)) ^ x;
      r = y[HashW-1 -: IdxW];
    end else if (fn == 4'd12) begin
      for (int m = 0; m < IdxW; m++) begin
        r[m] = h[32 + 2 * m + 5] ^ h[32 + 2 * m + 4];
      end
    end else if (fn == 4'd13) begin
      for (int m = 0; m < IdxW; m++) begin
        r[m] = h[2 * m + 5] ^ h[2 * m + 4];
      end
    end else if (fn == 4'd14) begin
      x = bfb_rotl(h, 6'd53);
      for (int m = 0; m < IdxW; m++) begin
        r[m] = x[3 * m] ^ x[3 * m + 1] ^ x[3 * m + 2];
      end
    end else begin
      x = bfb_rotl(h, 6'd60);
      for (int m = 0; m < IdxW; m++) begin
        r[m] = x[4 * m] ^ x[4 * m + 1] ^ x[4 * m + 2] ^ x[4 * m + 3];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/bfb_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter bank channels
// Valid/ready interfaces for the command stream and the read results.
// ----------------------------------------------------------------------------
interface bfb_in_if import bfb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [WordW-1:0]     hash_high;
  logic [WordW-1:0]     hash_low;
  logic [SelW-1:0]      filter_select;
  logic [IdxW-1:0]      bit_position;

  modport source (output valid, kind, hash_high, hash_low, filter_select,
                  bit_position, input ready);
  modport sink   (input valid, kind, hash_high, hash_low, filter_select,
                  bit_position, output ready);
endinterface

interface bfb_out_if import bfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] filter_word;

  modport source (output valid, filter_word, input ready);
  modport sink   (input valid, filter_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bfb_filter_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Filter word memory
// One filter's bits as 32-bit words; one write and one registered read port.
// ----------------------------------------------------------------------------
module bfb_filter_mem import bfb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [WordAddrW-1:0] rd_addr_i,
  output logic      [WordW-1:0]     rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [WordAddrW-1:0] wr_addr_i,
  input  wire logic [WordW-1:0]     wr_data_i
);

  logic [WordW-1:0] mem_q [WordsPerFilter];
  logic [WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* hw/rtl/bfb_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter index unit
// Maps one 64-bit hash to a bit index for each filter of the bank.
// ----------------------------------------------------------------------------
module bfb_hash import bfb_pkg::*; #(
  parameter int unsigned FnCount = 16
) (
  input  wire logic [HashW-1:0] hash_i,
  output logic      [IdxW-1:0]  idx_o [FnCount]
);

  for (genvar f = 0; f < FnCount; f++) begin : g_fn
    assign idx_o[f] = bfb_index(4'(f), hash_i);
  end

endmodule
`default_nettype wire

/* hw/rtl/bloom_filter_bank_insert_read_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter bank with insert and read
// A bank of 16384-bit Bloom filters, one word memory per filter. An insert
// sets one bit in every filter; a read returns a 32-bit window of one filter.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Payload
//  -------  ---------  ------------  ------------------------------------------
//  in_i     sink       valid/ready   kind, hash_high, hash_low, filter_select,
//                                    bit_position
//  out_o    source     valid/ready   filter_word (one per read transaction)
//
// In an insert, each filter memory reads the addressed word in the accept cycle
// and writes it back with the new bit in the next one. A read fetches the
// window's two words one after the other through the single read port of the
// selected filter's memory, the second unless the first is the filter's last.
// The result sits in an output register, so the next transaction is accepted
// while it waits; a read that finishes while the register is still full holds
// in its last cycle until the register drains.
// After reset a clearing pass writes zeros to all 512 words of every filter
// in parallel, so the block accepts no transaction until the pass is done.
// ----------------------------------------------------------------------------
module bloom_filter_bank_insert_read_top import bfb_pkg::*; #(
  parameter int unsigned FILTER_COUNT = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfb_in_if.sink    in_i,
  bfb_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_WR,
    S_RD_LO,
    S_RD_HI
  } state_e;

  localparam logic [WordAddrW-1:0] LastWord = WordAddrW'(WordsPerFilter - 1);

  state_e                 state_q, state_d;
  logic [WordAddrW-1:0]   clr_cnt_q, clr_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [WordW-1:0]       out_word_q, out_word_d;

  // Transaction payload held while it is being worked on.
  logic [IdxW-1:0]        idx_q [FILTER_COUNT];
  logic [WordAddrW-1:0]   word_q;
  logic [OffW-1:0]        off_q;
  logic [SelW-1:0]        sel_q;
  logic [WordW-1:0]       lo_q;
  logic                   hi_ok_q;

  logic                   in_fire;
  logic                   last_word;
  logic                   mem_rd_en;
  logic                   mem_wr_en;
  logic                   out_load;
  logic [IdxW-1:0]        idx_in [FILTER_COUNT];
  logic [WordW-1:0]       rd_data [FILTER_COUNT];
  logic [WordW-1:0]       sel_data;
  logic [WordW-1:0]       hi_word;
  logic [2*WordW-1:0]     window;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign last_word   = (word_q == LastWord);

  // Every memory reads on acceptance; the second word of a read window is
  // fetched unless the window already starts in the filter's last word.
  assign mem_rd_en = in_fire || ((state_q == S_RD_LO) && !last_word);
  assign mem_wr_en = (state_q == S_CLEAR) || (state_q == S_INS_WR);

  bfb_hash #(
    .FnCount (FILTER_COUNT)
  ) u_hash (
    .hash_i ({in_i.hash_high, in_i.hash_low}),
    .idx_o  (idx_in)
  );

  for (genvar f = 0; f < FILTER_COUNT; f++) begin : g_filter
    logic [WordAddrW-1:0] rd_addr;
    logic [WordAddrW-1:0] wr_addr;
    logic [WordW-1:0]     wr_data;

    always_comb begin
      if (state_q == S_IDLE) begin
        rd_addr = in_i.kind ? in_i.bit_position[IdxW-1:OffW] : idx_in[f][IdxW-1:OffW];
      end else begin
        rd_addr = word_q + WordAddrW'(1);
      end
      if (state_q == S_CLEAR) begin
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end else begin
        wr_addr = idx_q[f][IdxW-1:OffW];
        wr_data = rd_data[f] | (WordW'(1) << idx_q[f][OffW-1:0]);
      end
    end

    bfb_filter_mem u_mem (
      .clk_i     (clk_i),
      .rd_en_i   (mem_rd_en),
      .rd_addr_i (rd_addr),
      .rd_data_o (rd_data[f]),
      .wr_en_i   (mem_wr_en),
      .wr_addr_i (wr_addr),
      .wr_data_i (wr_data)
    );
  end

  // A filter number beyond the bank matches no memory and reads as zero.
  always_comb begin
    sel_data = '0;
    for (int f = 0; f < FILTER_COUNT; f++) begin
      if (sel_q == SelW'(f)) begin
        sel_data = rd_data[f];
      end
    end
  end

  assign hi_word = hi_ok_q ? sel_data : '0;
  assign window  = {hi_word, lo_q} >> off_q;
  assign out_load = (state_q == S_RD_HI) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + WordAddrW'(1);
        if (clr_cnt_q == LastWord) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = in_i.kind ? S_RD_LO : S_INS_WR;
        end
      end
      S_INS_WR: begin
        state_d = S_IDLE;
      end
      S_RD_LO: begin
        state_d = S_RD_HI;
      end
      S_RD_HI: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_word_d  = window[WordW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int f = 0; f < FILTER_COUNT; f++) begin
        idx_q[f] <= idx_in[f];
      end
      word_q <= in_i.bit_position[IdxW-1:OffW];
      off_q  <= in_i.bit_position[OffW-1:0];
      sel_q  <= in_i.filter_select;
    end
    if (state_q == S_RD_LO) begin
      lo_q    <= sel_data;
      hi_ok_q <= !last_word;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.filter_word = out_word_q;

  // The bank never takes a transaction before the clearing pass is done.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("transaction accepted during clearing pass");

  // Every accepted insert writes back in the following cycle.
  a_insert_writes_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.kind) |=> (state_q == S_INS_WR) && mem_wr_en)
    else $error("insert not followed by its write-back");

  // Memories are written only by the clearing pass or an insert write-back.
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> ((state_q == S_CLEAR) || (state_q == S_INS_WR)))
    else $error("memory written outside clear or insert");

  // A result appears only as the last step of a read.
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RD_HI))
    else $error("result without a completed read");

  // A read that completes with the output register full must wait.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RD_HI) && out_valid_q && !out_o.ready) |=> (state_q == S_RD_HI))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bloom filter bank insert/read testbench
// Drives insert and read transactions through a table of directed cases and
// then long random runs. A bit-accurate model of the sixteen filters predicts
// the read windows not typed in. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bfb_pkg::*;

  localparam int unsigned FilterCount = 16;
  localparam int unsigned NumDirected = 22;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned PhaseItems  = 232;
  localparam int unsigned StallLimit  = 4000;   // covers the clearing pass after reset
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned MaxReports  = 40;
  localparam realtime     ClkPeriod   = 12.0;

  typedef enum logic {
    KindInsert = 1'b0,
    KindRead   = 1'b1
  } bfb_kind_e;

  // One row of stimulus. When known is set the read result is typed in the
  // row itself instead of coming from the filter model.
  typedef struct {
    bfb_kind_e        kind;
    logic [WordW-1:0] hash_high;
    logic [WordW-1:0] hash_low;
    logic [SelW-1:0]  filter_select;
    logic [IdxW-1:0]  bit_position;
    bit               known;
    logic [WordW-1:0] known_word;
  } bfb_cmd_t;

  logic clk_i;
  logic rst_ni;

  bfb_in_if  cmd_if ();
  bfb_out_if rsp_if ();

  bloom_filter_bank_insert_read_top #(
    .FILTER_COUNT(FilterCount)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  // Sideband that travels with the command payload, so the monitor knows
  // whether the accepted read carries a typed-in result.
  logic             cmd_known;
  logic [WordW-1:0] cmd_known_word;

  // Filter model: one bit vector per filter, all zeros after reset.
  bit [FilterBits-1:0] bloom_bits [FilterCount];
  logic [WordW-1:0]    window_q [$];
  logic [WordW-1:0]    exp_word;
  logic [63:0]         recent_hashes [$];

  bit          idle_on;
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          cmd_fire;
  bit          rsp_fire;
  int unsigned rsp_hold;
  bfb_cmd_t    directed_cmds [NumDirected];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Filter model
  // --------------------------------------------------------------------------

  // Rotation amounts wrap at 64; a zero amount returns the hash unchanged.
  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
    int unsigned a;
    a = amt % 64;
    if (a == 0) return v;
    return (v << a) | (v >> (64 - a));
  endfunction

  // Bit index that hash function fn picks for the hash {hi, lo}.
  function automatic logic [IdxW-1:0] bloom_index(input int unsigned fn,
                                                  input logic [31:0] hi,
                                                  input logic [31:0] lo);
    logic [63:0]     h;
    logic [63:0]     x;
    logic [63:0]     y;
    logic [31:0]     w;
    logic [31:0]     f;
    logic [IdxW-1:0] idx;
    int              m;
    h   = {hi, lo};
    idx = '0;
    if (fn < 6) begin
      x   = rotl64(h, 14 * fn);
      idx = x[63:50];
    end else if (fn < 12) begin
      x   = rotl64(h, 14 * (fn - 6) + 10) ^ rotl64(h, 14 * (fn - 5) + 10);
      idx = x[63:50];
    end else if (fn < 14) begin
      // Fold each bit pair of one word, then drop the two lowest pairs.
      w = (fn == 12) ? hi : lo;
      f = ((w & 32'hAAAA_AAAA) >> 1) ^ (w & 32'h5555_5555);
      for (m = 0; m < IdxW; m++) idx[m] = f[2 * m + 4];
    end else if (fn == 14) begin
      x = rotl64(h, 53);
      y = ((x & 64'h4924_9249_2492_4924) >> 2)
        ^ ((x & 64'h2492_4924_9249_2492) >> 1)
        ^ (x & 64'h9249_2492_4924_9249);
      for (m = 0; m < IdxW; m++) idx[m] = y[3 * m];
    end else begin
      x = rotl64(h, 60);
      y = ((x & 64'h8888_8888_8888_8888) >> 3)
        ^ ((x & 64'h4444_4444_4444_4444) >> 2)
        ^ ((x & 64'h2222_2222_2222_2222) >> 1)
        ^ (x & 64'h1111_1111_1111_1111);
      for (m = 0; m < IdxW; m++) idx[m] = y[4 * m];
    end
    return idx;
  endfunction

  function automatic void mark_hash(input logic [31:0] hi, input logic [31:0] lo);
    for (int f = 0; f < FilterCount; f++) begin
      bloom_bits[f][bloom_index(f, hi, lo)] = 1'b1;
    end
  endfunction

  // Bits past the end of a filter, and filters that are not fitted, read 0.
  function automatic logic [WordW-1:0] predict_window(input logic [SelW-1:0] sel,
                                                      input logic [IdxW-1:0] pos);
    logic [WordW-1:0] word;
    int unsigned      b;
    word = '0;
    if (sel < FilterCount) begin
      for (int i = 0; i < WordW; i++) begin
        b = pos + i;
        if (b < FilterBits) word[i] = bloom_bits[sel][b];
      end
    end
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic bfb_cmd_t mk_cmd(input bfb_kind_e kind, input logic [31:0] hi,
                                      input logic [31:0] lo, input logic [3:0] sel,
                                      input logic [13:0] pos, input bit known,
                                      input logic [31:0] known_word);
    bfb_cmd_t c;
    c.kind          = kind;
    c.hash_high     = hi;
    c.hash_low      = lo;
    c.filter_select = sel;
    c.bit_position  = pos;
    c.known         = known;
    c.known_word    = known_word;
    return c;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random traffic leans on reads that land on bits the recent inserts set,
  // including a read right behind the insert, and on inserts of hashes that
  // repeat or differ in one bit, so that words are rewritten back to back.
  function automatic bfb_cmd_t random_cmd();
    bfb_cmd_t    c;
    int unsigned r;
    int          target;
    logic [63:0] h;
    c = mk_cmd(KindRead, $urandom(), $urandom(), 4'($urandom_range(0, 15)),
               IdxW'($urandom_range(0, FilterBits - 1)), 1'b0, '0);
    r = $urandom_range(0, 99);
    if (r < 42 || recent_hashes.size() == 0) begin
      c.kind = KindInsert;
      if (recent_hashes.size() != 0) begin
        case ($urandom_range(0, 7))
          0: {c.hash_high, c.hash_low} = recent_hashes[$];
          1, 2: begin
            h = recent_hashes[$] ^ (64'd1 << $urandom_range(0, 63));
            {c.hash_high, c.hash_low} = h;
          end
          default: ;
        endcase
      end
      h = {c.hash_high, c.hash_low};
      recent_hashes = {recent_hashes, h};
      if (recent_hashes.size() > 8) void'(recent_hashes.pop_front());
    end else if (r < 80) begin
      if ($urandom_range(0, 1) == 1) h = recent_hashes[$];
      else h = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
      target = int'(bloom_index(c.filter_select, h[63:32], h[31:0]))
             - int'($urandom_range(0, WordW - 1));
      if (target < 0) target = 0;
      c.bit_position = IdxW'(target);
    end else if (r < 90) begin
      c.bit_position = IdxW'($urandom_range(FilterBits - 40, FilterBits - 1));
    end
    return c;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the
  // transaction.
  task automatic send_cmd(input bfb_cmd_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.kind          <= c.kind;
    cmd_if.hash_high     <= c.hash_high;
    cmd_if.hash_low      <= c.hash_low;
    cmd_if.filter_select <= c.filter_select;
    cmd_if.bit_position  <= c.bit_position;
    cmd_known            <= c.known;
    cmd_known_word       <= c.known_word;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  // Holds the command channel idle until every read window has come back.
  // The first edge lets the monitor record the last accepted read.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (window_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls in bursts
  // --------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      rsp_hold = pick_gap();
      if (rsp_hold != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted command, checks every accepted result
  // and watches for a hang. Inputs are recorded before results are checked,
  // so the order within one edge never matters.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cmd_fire = cmd_if.valid && cmd_if.ready;
    rsp_fire = rsp_if.valid && rsp_if.ready;
    if (cmd_fire) begin
      if (cmd_if.kind == KindInsert) begin
        mark_hash(cmd_if.hash_high, cmd_if.hash_low);
      end else if (cmd_known) begin
        window_q = {window_q, cmd_known_word};
      end else begin
        window_q = {window_q, predict_window(cmd_if.filter_select, cmd_if.bit_position)};
      end
    end
    if (rsp_fire) begin
      if (window_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected read result, expected none, actual %h",
                   $time, rsp_if.filter_word);
      end else begin
        exp_word = window_q.pop_front();
        if (exp_word !== rsp_if.filter_word) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: filter_word mismatch, expected %h, actual %h",
                     $time, exp_word, rsp_if.filter_word);
        end
      end
    end
    quiet_cycles = (cmd_fire || rsp_fire) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.kind          = KindInsert;
    cmd_if.hash_high     = '0;
    cmd_if.hash_low      = '0;
    cmd_if.filter_select = '0;
    cmd_if.bit_position  = '0;
    cmd_known            = 1'b0;
    cmd_known_word       = '0;
    idle_on              = 1'b1;
    error_count          = 0;
    quiet_cycles         = 0;

    // Directed cases. Reads right after reset, and after the all-zero hash
    // has set bit 0 of every filter, have results that are typed in. Reads
    // also carry junk hash words, and inserts junk select and position.
    directed_cmds = '{
      // Empty filters, first word and the window that runs past the end.
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd0,  14'd0,     1'b1, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd15, 14'd16383, 1'b1, 32'h0),
      mk_cmd(KindRead,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd7,  14'd16352, 1'b1, 32'h0),
      // The zero hash: every rotation, zero amount included, gives index 0.
      mk_cmd(KindInsert, 32'h0000_0000, 32'h0000_0000, 4'd15, 14'd16383, 1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd0,  14'd0,     1'b1, 32'h1),
      mk_cmd(KindRead,   32'hFFFF_FFFF, 32'h0000_0000, 4'd15, 14'd0,     1'b1, 32'h1),
      // All ones: single rotations hit the last bit; XOR pairs and folds hit 0 or the top.
      mk_cmd(KindInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  14'd0,     1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd0,  14'd16352, 1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd5,  14'd16383, 1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd6,  14'd0,     1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd14, 14'd16360, 1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd15, 14'd0,     1'b0, 32'h0),
      // Single bits at the word edges and alternating patterns.
      mk_cmd(KindInsert, 32'h8000_0000, 32'h0000_0001, 4'd10, 14'd9999,  1'b0, 32'h0),
      mk_cmd(KindInsert, 32'h1234_5678, 32'h9ABC_DEF0, 4'd3,  14'd77,    1'b0, 32'h0),
      mk_cmd(KindInsert, 32'hAAAA_AAAA, 32'h5555_5555, 4'd0,  14'd0,     1'b0, 32'h0),
      mk_cmd(KindInsert, 32'h5555_5555, 32'hAAAA_AAAA, 4'd8,  14'd8192,  1'b0, 32'h0),
      // Unaligned windows spanning two words, one that ends partly past the
      // filter end, and an aligned one.
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd12, 14'd1,     1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd13, 14'd8191,  1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd3,  14'd16353, 1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd9,  14'd31,    1'b0, 32'h0),
      mk_cmd(KindRead,   32'hDEAD_BEEF, 32'h0BAD_F00D, 4'd1,  14'd5000,  1'b0, 32'h0),
      mk_cmd(KindRead,   32'h0000_0000, 32'h0000_0000, 4'd2,  14'd0,     1'b0, 32'h0)
    };

    // After reset is released the block clears its filter memories before it
    // accepts the first transaction.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    // Random phases. The second one runs without any idling on either side.
    // Between phases the sender stops until every window is back.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      idle_on = (p != 1);
      for (int n = 0; n < PhaseItems; n++) send_cmd(random_cmd());
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0 && window_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bfb_pkg.sv
hw/rtl/bfb_if.sv
hw/rtl/bfb_filter_mem.sv
hw/rtl/bfb_hash.sv
hw/rtl/bloom_filter_bank_insert_read_top.sv
bench/tb_top.sv
